/* rtl/erbc_pkg.sv */
`default_nettype none

package erbc_pkg;

    // fixed field widths
    localparam int OFFSET_W = 32;
    localparam int LENGTH_W = 11;
    localparam int LIMIT_W  = 11;
    localparam int BYTE_W   = 8;

    // default largest chunk span
    localparam int MAX_CHUNK_DEF = 1024;

    // value of an erased flash byte
    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

endpackage

`default_nettype wire

/* rtl/erbc_if.sv */
`default_nettype none

// image byte channel
interface erbc_byte_if;
    import erbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

// program chunk channel
interface erbc_chunk_if;
    import erbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] chunk_offset;
    logic [LENGTH_W-1:0] chunk_length;
    logic                last_chunk;

    modport source (output valid, output chunk_offset, output chunk_length,
                    output last_chunk, input ready);
    modport sink   (input valid, input chunk_offset, input chunk_length,
                    input last_chunk, output ready);
endinterface

`default_nettype wire

/* rtl/erased_byte_skipping_chunker_unit.sv */
`default_nettype none

// erased byte skipping chunker
//
// i_byte carries one flash image byte per request, in address order, with
// final_byte set on the last byte. o_chunk carries one program command per
// request: start offset, length (ends on a byte that is not 0xff) and a flag
// on the chunk closed by the final byte. i_cfg_we / i_cfg_wdata write the
// chunk limit (0 acts as 1, above MAX_CHUNK acts as MAX_CHUNK); write it only
// while the block is idle.
//
// throughput: one byte per cycle while i_byte is not held off. the scan
// state is updated in the cycle a byte is taken, and a closed chunk lands
// in the output register, so a command is on o_chunk in the cycle after
// the byte that closed it. a byte that closes no chunk produces nothing.
// stall: while the output register holds a command that o_chunk has not
// taken, i_byte is held off; a byte is taken whenever the output register is
// empty or is being emptied in the same cycle.
// reset: offset counter back to zero, no chunk open, output empty, chunk
// limit back to MAX_CHUNK.

module erased_byte_skipping_chunker_unit #(
    parameter int MAX_CHUNK = erbc_pkg::MAX_CHUNK_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [erbc_pkg::LIMIT_W-1:0] i_cfg_wdata,
    erbc_byte_if.sink                   i_byte,
    erbc_chunk_if.source                o_chunk
);
    import erbc_pkg::*;

    // width of the clamped limit
    localparam int EffW = $clog2(MAX_CHUNK + 1);

    // scan state
    logic [OFFSET_W-1:0] r_pos, n_pos;
    logic                r_open, n_open;
    logic [OFFSET_W-1:0] r_start, n_start;
    logic [OFFSET_W-1:0] r_last, n_last;

    // clamped chunk limit, kept ready to compare
    logic [EffW-1:0]     r_eff_limit, n_eff_limit;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [OFFSET_W-1:0] r_out_offset, n_out_offset;
    logic [LENGTH_W-1:0] r_out_length, n_out_length;
    logic                r_out_last, n_out_last;

    logic                take;
    logic                is_data;
    logic                open_now;
    logic [OFFSET_W-1:0] start_now;
    logic [OFFSET_W-1:0] last_now;
    logic [OFFSET_W-1:0] span;
    logic                emit;
    logic [LENGTH_W-1:0] length;

    // output register empty or draining this cycle
    assign i_byte.ready = ~r_out_valid | o_chunk.ready;
    assign take         = i_byte.valid & i_byte.ready;

    assign o_chunk.valid        = r_out_valid;
    assign o_chunk.chunk_offset = r_out_offset;
    assign o_chunk.chunk_length = r_out_length;
    assign o_chunk.last_chunk   = r_out_last;

    // chunk opens on the first non-erased byte, tracks its last data byte
    assign is_data   = (i_byte.byte_value != ERASED_BYTE);
    assign open_now  = r_open | is_data;
    assign start_now = r_open ? r_start : r_pos;
    assign last_now  = is_data ? r_pos : r_last;

    // span counted from chunk start up to and including this byte, mod 2^32
    assign span = r_pos - start_now + OFFSET_W'(1);

    // close on a full window or on the final byte
    assign emit = open_now
                & ((span >= OFFSET_W'(r_eff_limit)) | i_byte.final_byte);

    // trimmed length, only the low bits are kept
    assign length = last_now[LENGTH_W-1:0] - start_now[LENGTH_W-1:0]
                  + LENGTH_W'(1);

    always_comb begin
        n_pos   = r_pos;
        n_open  = r_open;
        n_start = r_start;
        n_last  = r_last;
        if (take) begin
            n_start = start_now;
            n_last  = last_now;
            n_open  = open_now & ~emit & ~i_byte.final_byte;
            // final byte starts a new image at offset zero
            n_pos   = i_byte.final_byte ? '0 : r_pos + OFFSET_W'(1);
        end
    end

    // clamp the written limit to 1 .. MAX_CHUNK
    always_comb begin
        n_eff_limit = r_eff_limit;
        if (i_cfg_we) begin
            priority if (i_cfg_wdata == '0) begin
                n_eff_limit = EffW'(1);
            end else if (OFFSET_W'(i_cfg_wdata) > OFFSET_W'(MAX_CHUNK)) begin
                n_eff_limit = EffW'(MAX_CHUNK);
            end else begin
                n_eff_limit = EffW'(i_cfg_wdata);
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_offset = r_out_offset;
        n_out_length = r_out_length;
        n_out_last   = r_out_last;
        if (o_chunk.ready) begin
            n_out_valid = 1'b0;
        end
        if (take && emit) begin
            n_out_valid  = 1'b1;
            n_out_offset = start_now;
            n_out_length = length;
            n_out_last   = i_byte.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
            r_eff_limit <= EffW'(MAX_CHUNK);
        end else begin
            r_pos       <= n_pos;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
            r_eff_limit <= n_eff_limit;
        end
    end

    // payload, meaningful only while a chunk is open or a command is held
    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_last       <= n_last;
        r_out_offset <= n_out_offset;
        r_out_length <= n_out_length;
        r_out_last   <= n_out_last;
    end

endmodule

`default_nettype wire
